// ===== src/rcpsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpsp_pkg
// Shared types and constants of the stick-stepped pulse width controller:
// configuration register map, reset values, result codes, divider handshake.
// ----------------------------------------------------------------------------
package rcpsp_pkg;

    // Field widths
    localparam int unsigned US_W    = 12;   // pulse widths in microseconds
    localparam int unsigned CFG16_W = 16;   // 16-bit registers
    localparam int unsigned TIME_W  = 32;   // free-running timestamps
    localparam int unsigned IDX_W   = 3;    // register index
    localparam int unsigned PROD_W  = US_W + CFG16_W;  // width * duty_max
    localparam int unsigned DIV_STEPS = PROD_W;         // one quotient bit a cycle

    // Register indexes
    localparam logic [IDX_W-1:0] REG_CENTER     = 3'd0;
    localparam logic [IDX_W-1:0] REG_DEADBAND   = 3'd1;
    localparam logic [IDX_W-1:0] REG_LIMIT_LOW  = 3'd2;
    localparam logic [IDX_W-1:0] REG_LIMIT_HIGH = 3'd3;
    localparam logic [IDX_W-1:0] REG_STEP       = 3'd4;
    localparam logic [IDX_W-1:0] REG_LONG_PRESS = 3'd5;
    localparam logic [IDX_W-1:0] REG_PERIOD     = 3'd6;
    localparam logic [IDX_W-1:0] REG_DUTY_MAX   = 3'd7;

    // Register reset values
    localparam logic [US_W-1:0]    RST_CENTER     = 12'd1500;
    localparam logic [US_W-1:0]    RST_DEADBAND   = 12'd50;
    localparam logic [US_W-1:0]    RST_LIMIT_LOW  = 12'd1100;
    localparam logic [US_W-1:0]    RST_LIMIT_HIGH = 12'd1900;
    localparam logic [US_W-1:0]    RST_STEP       = 12'd50;
    localparam logic [CFG16_W-1:0] RST_LONG_PRESS = 16'd500;
    localparam logic [CFG16_W-1:0] RST_PERIOD     = 16'd2049;
    localparam logic [CFG16_W-1:0] RST_DUTY_MAX   = 16'd255;

    // Stick direction codes (2-bit signed)
    localparam logic signed [1:0] MODE_UP   = 2'sb01;
    localparam logic signed [1:0] MODE_DOWN = 2'sb11;

    localparam logic [CFG16_W-1:0] DUTY_SAT = 16'hFFFF;

    // Configuration register set
    typedef struct packed {
        logic [US_W-1:0]    center_us;
        logic [US_W-1:0]    deadband_us;
        logic [US_W-1:0]    limit_low_us;
        logic [US_W-1:0]    limit_high_us;
        logic [US_W-1:0]    step_us;
        logic [CFG16_W-1:0] long_press_ms;
        logic [CFG16_W-1:0] period_us;
        logic [CFG16_W-1:0] duty_max;
    } cfg_t;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic [PROD_W-1:0]  dividend;
        logic [CFG16_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== src/rcpsp_cfg.sv =====
// ----------------------------------------------------------------------------
// rcpsp_cfg
// Configuration register file: eight write-only registers, loaded by index.
// ----------------------------------------------------------------------------
module rcpsp_cfg
    import rcpsp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG16_W-1:0]   cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // Register writes; 12-bit registers keep the low bits of the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_us     <= RST_CENTER;
            cfg_reg.deadband_us   <= RST_DEADBAND;
            cfg_reg.limit_low_us  <= RST_LIMIT_LOW;
            cfg_reg.limit_high_us <= RST_LIMIT_HIGH;
            cfg_reg.step_us       <= RST_STEP;
            cfg_reg.long_press_ms <= RST_LONG_PRESS;
            cfg_reg.period_us     <= RST_PERIOD;
            cfg_reg.duty_max      <= RST_DUTY_MAX;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CENTER:     cfg_reg.center_us     <= cfg_wdata[US_W-1:0];
                REG_DEADBAND:   cfg_reg.deadband_us   <= cfg_wdata[US_W-1:0];
                REG_LIMIT_LOW:  cfg_reg.limit_low_us  <= cfg_wdata[US_W-1:0];
                REG_LIMIT_HIGH: cfg_reg.limit_high_us <= cfg_wdata[US_W-1:0];
                REG_STEP:       cfg_reg.step_us       <= cfg_wdata[US_W-1:0];
                REG_LONG_PRESS: cfg_reg.long_press_ms <= cfg_wdata;
                REG_PERIOD:     cfg_reg.period_us     <= cfg_wdata;
                REG_DUTY_MAX:   cfg_reg.duty_max      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/rcpsp_div.sv =====
// ----------------------------------------------------------------------------
// rcpsp_div
// Serial restoring divider: one quotient bit per cycle, done pulse at the end.
// Quotient holds until the next start. A zero divisor is handled by the user.
// ----------------------------------------------------------------------------
module rcpsp_div
    import rcpsp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int unsigned CNT_W = $clog2(DIV_STEPS);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CFG16_W-1:0] rem_reg;
    logic [PROD_W-1:0]  quo_reg;
    logic [CFG16_W-1:0] dvsr_reg;

    logic [CFG16_W:0]   trial;
    logic               fits;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, quo_reg[PROD_W-1]};
    assign fits  = (trial >= {1'b0, dvsr_reg});

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_STEPS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out of the top while quotient shifts in
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
            dvsr_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? CFG16_W'(trial - {1'b0, dvsr_reg}) : trial[CFG16_W-1:0];
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== src/rc_pulse_step_position_control.sv =====
// ----------------------------------------------------------------------------
// rc_pulse_step_position_control
// Times an RC servo pulse and steps an output pulse width from it on each
// deflected control tick (a long press jumps it to a limit), reporting each
// new width with its PWM duty value.
// Each input transaction is a pin edge (action 0) or a control tick (action 1).
// A pin edge only updates the measurement and leaves the block ready.
// A tick that finds the stick neutral passes MAG and CLASS, gives no result.
// A deflected tick passes the sequencer states MAG, CLASS, CLAMP and MUL for
// classify, step, clamp and multiply, then the serial divider that divides
// width * duty_max by period_us, before its result is offered.
// s_ready is low while a tick is in work. A finished result sits in the output
// register, so edges keep being accepted while it waits for m_ready.
// ----------------------------------------------------------------------------
module rc_pulse_step_position_control
    import rcpsp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_wr_en,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [CFG16_W-1:0]        cfg_wdata,
    // input channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic                      s_pin_level,
    input  logic [TIME_W-1:0]         s_now_us,
    input  logic [TIME_W-1:0]         s_now_ms,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [1:0]         m_mode,
    output logic [US_W-1:0]           m_out_width_us,
    output logic [CFG16_W-1:0]        m_duty_value
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_CLASS,
        ST_CLAMP,
        ST_MUL,
        ST_DSTART,
        ST_DWAIT,
        ST_OUT
    } state_t;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t state_reg, state_next;

    // block state
    logic [TIME_W-1:0]       pulse_start_reg;
    logic [TIME_W-1:0]       meas_reg;
    logic [US_W-1:0]         out_width_reg;
    logic [TIME_W-1:0]       neutral_since_reg;

    // per-tick work registers
    logic [TIME_W-1:0]       width_reg;
    logic [TIME_W-1:0]       now_ms_reg;
    logic [TIME_W-1:0]       mag_reg;
    logic                    up_reg;
    logic                    nz_reg;
    logic                    held_long_reg;
    logic signed [US_W+1:0]  sum_reg;
    logic [PROD_W-1:0]       prod_reg;

    // result register
    logic                    m_valid_reg;
    logic signed [1:0]       m_mode_reg;
    logic [US_W-1:0]         m_width_reg;
    logic [CFG16_W-1:0]      m_duty_reg;

    logic                    s_fire;
    logic                    out_free;
    logic                    gt_center;
    logic [TIME_W-1:0]       mag_calc;
    logic                    neutral;
    logic [TIME_W-1:0]       held;
    logic signed [US_W+1:0]  step_s;
    logic signed [US_W+1:0]  width_s;
    logic signed [US_W+1:0]  lo_s;
    logic signed [US_W+1:0]  hi_s;
    logic signed [US_W+1:0]  clamp_lo;
    logic signed [US_W+1:0]  clamp_hi;
    logic [US_W-1:0]         new_width;
    logic [CFG16_W-1:0]      duty;

    rcpsp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rcpsp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Distance from center; below center the width fits in 12 bits
    assign gt_center = (width_reg > {{(TIME_W-US_W){1'b0}}, cfg.center_us});
    assign mag_calc  = gt_center
                     ? width_reg - {{(TIME_W-US_W){1'b0}}, cfg.center_us}
                     : {{(TIME_W-US_W){1'b0}}, cfg.center_us - width_reg[US_W-1:0]};

    // Neutral: no new pulse, or inside the deadband
    assign neutral = !nz_reg || (mag_reg < {{(TIME_W-US_W){1'b0}}, cfg.deadband_us});
    assign held    = now_ms_reg - neutral_since_reg;

    // Step and clamp on 14-bit signed values
    assign step_s  = $signed({2'b00, cfg.step_us});
    assign width_s = $signed({2'b00, out_width_reg});
    assign lo_s    = $signed({2'b00, cfg.limit_low_us});
    assign hi_s    = $signed({2'b00, cfg.limit_high_us});
    assign clamp_lo = (sum_reg < lo_s) ? lo_s : sum_reg;
    assign clamp_hi = (clamp_lo > hi_s) ? hi_s : clamp_lo;

    always_comb begin
        if (held_long_reg) begin
            new_width = up_reg ? cfg.limit_high_us : cfg.limit_low_us;
        end else begin
            new_width = clamp_hi[US_W-1:0];
        end
    end

    // Duty value, saturated on overflow or a zero period
    assign duty = ((cfg.period_us == '0) || (|div_rsp.quotient[PROD_W-1:CFG16_W]))
                ? DUTY_SAT : div_rsp.quotient[CFG16_W-1:0];

    assign div_req.start    = (state_reg == ST_DSTART);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = cfg.period_us;

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_fire && s_action) state_next = ST_MAG;
            ST_MAG:    state_next = ST_CLASS;
            ST_CLASS:  state_next = neutral ? ST_IDLE : ST_CLAMP;
            ST_CLAMP:  state_next = ST_MUL;
            ST_MUL:    state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT:  if (div_rsp.done) state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // State, block state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            pulse_start_reg   <= '0;
            meas_reg          <= '0;
            out_width_reg     <= RST_CENTER;
            neutral_since_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;

            // edges update the measurement, ticks consume it
            if (s_fire) begin
                if (s_action) begin
                    meas_reg <= '0;
                end else if (s_pin_level) begin
                    pulse_start_reg <= s_now_us;
                end else begin
                    meas_reg <= s_now_us - pulse_start_reg;
                end
            end

            if (state_reg == ST_CLASS && neutral) begin
                neutral_since_reg <= now_ms_reg;
            end

            if (state_reg == ST_CLAMP) begin
                out_width_reg <= new_width;
            end

            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Work registers and result payload
    always_ff @(posedge aclk) begin
        if (s_fire && s_action) begin
            width_reg  <= meas_reg;
            now_ms_reg <= s_now_ms;
        end

        if (state_reg == ST_MAG) begin
            mag_reg <= mag_calc;
            up_reg  <= gt_center;
            nz_reg  <= (width_reg != '0);
        end

        if (state_reg == ST_CLASS) begin
            held_long_reg <= (held > {{(TIME_W-CFG16_W){1'b0}}, cfg.long_press_ms});
            sum_reg       <= up_reg ? width_s + step_s : width_s - step_s;
        end

        if (state_reg == ST_MUL) begin
            prod_reg <= {{CFG16_W{1'b0}}, out_width_reg} * {{US_W{1'b0}}, cfg.duty_max};
        end

        if (state_reg == ST_OUT && out_free) begin
            m_mode_reg  <= up_reg ? MODE_UP : MODE_DOWN;
            m_width_reg <= out_width_reg;
            m_duty_reg  <= duty;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mode         = m_mode_reg;
    assign m_out_width_us = m_width_reg;
    assign m_duty_value   = m_duty_reg;

endmodule

// ===== src/rcpsp_checker.sv =====
// ----------------------------------------------------------------------------
// rcpsp_checker
// Port-level checks of the pulse width controller, bound to the top level.
// ----------------------------------------------------------------------------
module rcpsp_checker
    import rcpsp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_action,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [1:0]  m_mode,
    input logic [US_W-1:0]    m_out_width_us,
    input logic [CFG16_W-1:0] m_duty_value
);

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // An accepted tick keeps the input side busy in the next cycle
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_action) |=> !s_ready)
        else $error("input ready right after a tick");

    // An accepted edge leaves the input side ready in the next cycle
    a_edge_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_action) |=> s_ready)
        else $error("input not ready after an edge");

    // A new result is only produced while a tick is in work
    a_result_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while idle");

    // A stalled result holds its payload
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_mode)
            && $stable(m_out_width_us) && $stable(m_duty_value)))
        else $error("result changed while stalled");

endmodule

bind rc_pulse_step_position_control rcpsp_checker u_rcpsp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_action       (s_action),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_mode         (m_mode),
    .m_out_width_us (m_out_width_us),
    .m_duty_value   (m_duty_value)
);
